// ===== rtl/srot_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srot_pkg: shared types and constants for the segment/rectangle occlusion test
// Holds the request and result payloads, the controller states and the
// command and status groups that join the controller to the datapath.
// ============================================================================
package srot_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 4;

    // Slab numerators reach left + width - start, which needs two bits more
    // than one coordinate. Products of two such values are twice as wide.
    localparam int NUM_WIDTH  = COORD_WIDTH + 2;
    localparam int PROD_WIDTH = 2 * NUM_WIDTH;

    // A delta below this many LSBs in magnitude counts as zero.
    localparam logic signed [NUM_WIDTH-1:0] ZERO_DELTA =
        NUM_WIDTH'(((1 << FRAC_BITS) / 10000) + 1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] rect_left;
        logic signed [COORD_WIDTH-1:0] rect_top;
        logic        [COORD_WIDTH-1:0] rect_width;
        logic        [COORD_WIDTH-1:0] rect_height;
        logic                          last_rect;
    } t_in;

    typedef struct packed {
        logic crosses;
        logic skipped;
        logic blocked;
        logic last_result;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_AXIS,
        ST_UPD,
        ST_MUL3,
        ST_CHK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;       // capture the request
        logic init;       // reset the clip window and select the x axis
        logic mul12;      // form the entry and exit products for this axis
        logic upd;        // tighten entry and exit from those products
        logic mul3;       // form the entry-versus-exit products
        logic next_axis;  // move on to the y axis
        logic set_cross;  // the segment passes through the rectangle
        logic emit;       // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic skip;       // rectangle contains an endpoint
        logic zero;       // delta on the current axis is zero
        logic bounds_ok;  // start lies within the closed slab of this axis
        logic gt3;        // entry lies beyond exit
        logic axis_y;     // the y axis is selected
        logic out_free;   // the result register can take a new result
    } t_dp_sts;

endpackage

// ===== rtl/segment_rect_occlusion_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segment_rect_occlusion_test: segment versus rectangle occlusion test
// Exact fixed-point slab clipping of a segment against a stream of
// axis-aligned rectangles, with a running blocked flag per obstacle list.
// ============================================================================
// Each input request carries the segment end points and one rectangle in
// signed Q12.4, plus a flag that marks the last rectangle of a list. It is
// taken on the input channel when i_in_valid and o_in_ready are both high.
// Each request yields exactly one result on the output channel: whether this
// rectangle crosses the segment, whether it was skipped because it contains
// an end point, the OR of crossings over the list so far, and a copy of the
// last flag. The OR clears after the result of the last rectangle.
// A request goes through a setup state and then straight to the final
// state when the rectangle is skipped. Otherwise the controller walks each
// axis through a multiply, an update, a second multiply and a check, or
// only a bounds check when the axis has no movement, on one shared bank of
// four 18x18 multipliers, one request at a time. The controller is back in
// idle as the result loads, and only then takes the next request.
// The result sits in an output register. While the receiver stalls, the
// block takes the next request and works on it; it then waits in its final
// state until the register is free. Reset clears the controller, the result
// valid flag and the blocked accumulator.
// ============================================================================
module segment_rect_occlusion_test (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srot_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output srot_pkg::t_out o_out_data
);
    import srot_pkg::*;

    // Commands flow from the controller; status flows back.
    t_dp_cmd cmd;
    t_dp_sts sts;

    srot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the request, the clip window and the result.
    srot_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/srot_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srot_ctrl: sequencing controller
// Walks one request through the containment check and the two slab clips,
// issuing commands to the datapath and branching on its status.
// ============================================================================
module srot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  srot_pkg::t_dp_sts i_sts,
    output srot_pkg::t_dp_cmd o_cmd
);
    import srot_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.init = 1'b1;
                n_state    = i_sts.skip ? ST_FIN : ST_AXIS;
            end
            ST_AXIS: begin
                if (i_sts.zero) begin
                    // A still axis is a plain bounds check on the start point.
                    if (!i_sts.bounds_ok) begin
                        n_state = ST_FIN;
                    end else if (i_sts.axis_y) begin
                        o_cmd.set_cross = 1'b1;
                        n_state         = ST_FIN;
                    end else begin
                        o_cmd.next_axis = 1'b1;
                    end
                end else begin
                    o_cmd.mul12 = 1'b1;
                    n_state     = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = ST_CHK;
            end
            ST_CHK: begin
                if (i_sts.gt3) begin
                    n_state = ST_FIN;
                end else if (i_sts.axis_y) begin
                    o_cmd.set_cross = 1'b1;
                    n_state         = ST_FIN;
                end else begin
                    o_cmd.next_axis = 1'b1;
                    n_state         = ST_AXIS;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/srot_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srot_dp: occlusion datapath
// Request register, containment logic, slab arithmetic with one bank of
// four multipliers, the clip window, the blocked accumulator and the result
// register.
// ============================================================================
module srot_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srot_pkg::t_in     i_in_data,
    input  srot_pkg::t_dp_cmd i_cmd,
    output srot_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output srot_pkg::t_out    o_out_data
);
    import srot_pkg::*;

    t_in  r_item;
    logic r_axis_y;
    logic r_cross;
    logic r_skip;
    logic r_blocked_acc;
    logic r_out_valid;
    t_out r_out;

    logic signed [NUM_WIDTH-1:0]  r_en, r_ed, r_xn, r_xd;
    logic signed [PROD_WIDTH-1:0] r_pa, r_pb, r_pc, r_pd;

    // Extended corner coordinates; the far edges are formed without wrap.
    logic signed [NUM_WIDTH-1:0] sx, sy, ex, ey, left, top, right, bottom;
    logic signed [NUM_WIDTH-1:0] s, e, lo, hi, d, nlo, nhi, den;
    // Operands of the first two multipliers, shared by both product steps.
    logic signed [NUM_WIDTH-1:0] ma_a, ma_b, mb_a, mb_b;
    logic                        skip_c, blk;

    always_comb begin
        sx     = NUM_WIDTH'(r_item.start_x);
        sy     = NUM_WIDTH'(r_item.start_y);
        ex     = NUM_WIDTH'(r_item.end_x);
        ey     = NUM_WIDTH'(r_item.end_y);
        left   = NUM_WIDTH'(r_item.rect_left);
        top    = NUM_WIDTH'(r_item.rect_top);
        right  = left + $signed(NUM_WIDTH'(r_item.rect_width));
        bottom = top + $signed(NUM_WIDTH'(r_item.rect_height));

        skip_c = (sx >= left && sx < right && sy >= top && sy < bottom) ||
                 (ex >= left && ex < right && ey >= top && ey < bottom);

        s  = r_axis_y ? sy : sx;
        e  = r_axis_y ? ey : ex;
        lo = r_axis_y ? top : left;
        hi = r_axis_y ? bottom : right;
        d  = e - s;

        // Orient the slab so that the denominator is positive.
        if (d > 0) begin
            nlo = lo - s;
            nhi = hi - s;
            den = d;
        end else begin
            nlo = s - hi;
            nhi = s - lo;
            den = -d;
        end

        // The entry-versus-exit step reuses the entry multipliers.
        ma_a = i_cmd.mul3 ? r_en : nlo;
        ma_b = i_cmd.mul3 ? r_xd : r_ed;
        mb_a = i_cmd.mul3 ? r_xn : r_en;
        mb_b = i_cmd.mul3 ? r_ed : den;
    end

    assign o_sts.skip      = skip_c;
    assign o_sts.zero      = (d < ZERO_DELTA) && (d > -ZERO_DELTA);
    assign o_sts.bounds_ok = !(s < lo || s > hi);
    assign o_sts.gt3       = r_pa > r_pb;
    assign o_sts.axis_y    = r_axis_y;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.init) begin
            r_en     <= '0;
            r_ed     <= NUM_WIDTH'(1);
            r_xn     <= NUM_WIDTH'(1);
            r_xd     <= NUM_WIDTH'(1);
            r_axis_y <= 1'b0;
            r_cross  <= 1'b0;
            r_skip   <= skip_c;
        end
        if (i_cmd.next_axis) begin
            r_axis_y <= 1'b1;
        end
        if (i_cmd.set_cross) begin
            r_cross <= 1'b1;
        end
        if (i_cmd.mul12 || i_cmd.mul3) begin
            r_pa <= PROD_WIDTH'(ma_a) * PROD_WIDTH'(ma_b);
            r_pb <= PROD_WIDTH'(mb_a) * PROD_WIDTH'(mb_b);
        end
        if (i_cmd.mul12) begin
            r_pc <= PROD_WIDTH'(r_xn) * PROD_WIDTH'(den);
            r_pd <= PROD_WIDTH'(nhi) * PROD_WIDTH'(r_xd);
        end
        if (i_cmd.upd) begin
            if (r_pa > r_pb) begin
                r_en <= nlo;
                r_ed <= den;
            end
            if (r_pc > r_pd) begin
                r_xn <= nhi;
                r_xd <= den;
            end
        end
        if (i_cmd.emit) begin
            r_out.crosses     <= r_cross;
            r_out.skipped     <= r_skip;
            r_out.blocked     <= blk;
            r_out.last_result <= r_item.last_rect;
        end
    end

    assign blk = r_blocked_acc | r_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked_acc <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_blocked_acc <= r_item.last_rect ? 1'b0 : blk;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for segment_rect_occlusion_test
// Directed and random obstacle lists go through the request channel. A
// predictor of the exact slab clip and the running blocked flag forms the
// expected result of each accepted request. A checker compares every result
// against the oldest pending prediction while both sides idle and stall at
// random.
// ============================================================================
module testbench;

    import srot_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block.
    // Every input starts at a known value. After that, inputs only change by
    // nonblocking assignment at the rising edge, so the block always samples
    // the values that were set before that edge.
    // ------------------------------------------------------------------------
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    segment_rect_occlusion_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictions wait here, oldest first, until the block delivers them.
    t_out pending_verdicts[$];
    // The predictor's copy of the blocked flag of the list in progress.
    logic list_blocked = 1'b0;
    int   mismatch_count = 0;
    // When set, neither the sender nor the receiver idles.
    bit   no_idle = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor.
    // The rectangle is skipped when it holds either endpoint with half-open
    // bounds, so a rectangle of zero width or height never holds a point.
    // Otherwise the segment is clipped to the parameter window 0..1, first on
    // x and then on y. Entry and exit are kept as fractions with positive
    // denominators and compared by cross products, which is exact. An axis
    // with a zero delta only asks whether the start lies in the closed slab.
    // All values stay far below 2^31, so 64-bit products cannot overflow.
    // ------------------------------------------------------------------------
    function automatic t_out predict_occlusion(input t_in req);
        longint s[2], e[2], lo[2], hi[2];
        longint enter_n, enter_d, exit_n, exit_d;
        longint d, n_lo, n_hi, den, zero_lim;
        logic   skip, hit;
        t_out   res;
        s[0]  = longint'($signed(req.start_x));
        s[1]  = longint'($signed(req.start_y));
        e[0]  = longint'($signed(req.end_x));
        e[1]  = longint'($signed(req.end_y));
        lo[0] = longint'($signed(req.rect_left));
        lo[1] = longint'($signed(req.rect_top));
        hi[0] = lo[0] + longint'(req.rect_width);
        hi[1] = lo[1] + longint'(req.rect_height);
        zero_lim = longint'(ZERO_DELTA);

        skip = (s[0] >= lo[0] && s[0] < hi[0] && s[1] >= lo[1] && s[1] < hi[1]) ||
               (e[0] >= lo[0] && e[0] < hi[0] && e[1] >= lo[1] && e[1] < hi[1]);
        hit = 1'b0;
        if (!skip) begin
            enter_n = 0;
            enter_d = 1;
            exit_n  = 1;
            exit_d  = 1;
            hit     = 1'b1;
            for (int a = 0; a < 2 && hit; a++) begin
                d = e[a] - s[a];
                if (d < zero_lim && d > -zero_lim) begin
                    hit = !(s[a] < lo[a] || s[a] > hi[a]);
                end else begin
                    if (d > 0) begin
                        n_lo = lo[a] - s[a];
                        n_hi = hi[a] - s[a];
                        den  = d;
                    end else begin
                        n_lo = s[a] - hi[a];
                        n_hi = s[a] - lo[a];
                        den  = -d;
                    end
                    if (n_lo * enter_d > enter_n * den) begin
                        enter_n = n_lo;
                        enter_d = den;
                    end
                    if (exit_n * den > n_hi * exit_d) begin
                        exit_n = n_hi;
                        exit_d = den;
                    end
                    hit = !(enter_n * exit_d > exit_n * enter_d);
                end
            end
        end
        res.crosses     = hit;
        res.skipped     = skip;
        res.blocked     = list_blocked | hit;
        res.last_result = req.last_rect;
        // The flag clears once the last rectangle of a list has been judged.
        list_blocked    = req.last_rect ? 1'b0 : res.blocked;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers for building requests and random gaps.
    // ------------------------------------------------------------------------
    function automatic t_in make_req(input int sx, sy, ex, ey, left, top, w, h,
                                     input bit last);
        t_in req;
        req.start_x     = COORD_WIDTH'(sx);
        req.start_y     = COORD_WIDTH'(sy);
        req.end_x       = COORD_WIDTH'(ex);
        req.end_y       = COORD_WIDTH'(ey);
        req.rect_left   = COORD_WIDTH'(left);
        req.rect_top    = COORD_WIDTH'(top);
        req.rect_width  = COORD_WIDTH'(w);
        req.rect_height = COORD_WIDTH'(h);
        req.last_rect   = last;
        return req;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // A coordinate in a window around the origin, where crossings are common.
    function automatic int near_coord();
        return int'($urandom_range(0, 800)) - 400;
    endfunction

    // ------------------------------------------------------------------------
    // Request sender.
    // Valid is only lowered when a gap follows, so back-to-back requests keep
    // it high without a low pulse inside one time step. The prediction is
    // formed at the accepting edge, which keeps the predictor's blocked flag
    // in step with the order the block takes requests in.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_in req);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_verdicts.push_back(predict_occlusion(req));
    endtask

    // The sender holds off until every result it is owed has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: ready drops for random stretches, short ones mostly.
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (no_idle) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Result checker.
    // Each accepted result is matched with the oldest prediction, one field
    // at a time. A result that arrives with nothing pending is a failure too.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with no pending request, actual %b",
                         $time, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_out_data.crosses !== want.crosses) begin
                    $display("%0t: crosses mismatch, expected %b, actual %b",
                             $time, want.crosses, o_out_data.crosses);
                    mismatch_count++;
                end
                if (o_out_data.skipped !== want.skipped) begin
                    $display("%0t: skipped mismatch, expected %b, actual %b",
                             $time, want.skipped, o_out_data.skipped);
                    mismatch_count++;
                end
                if (o_out_data.blocked !== want.blocked) begin
                    $display("%0t: blocked mismatch, expected %b, actual %b",
                             $time, want.blocked, o_out_data.blocked);
                    mismatch_count++;
                end
                if (o_out_data.last_result !== want.last_result) begin
                    $display("%0t: last_result mismatch, expected %b, actual %b",
                             $time, want.last_result, o_out_data.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests. Each one closes its own list and then drains, so the
    // sender pauses with nothing in flight several times over the run.
    // ------------------------------------------------------------------------

    // Endpoint containment, with half-open edges and empty rectangles.
    task automatic test_containment();
        send_request(make_req(0, 0, 100, 100, -10, -10, 20, 20, 1'b0));  // start inside
        send_request(make_req(0, 0, 100, 100, 90, 90, 20, 20, 1'b0));    // end inside
        // The start sits on the right edge, which the half-open test leaves out.
        send_request(make_req(20, 0, 40, 0, 0, -10, 20, 20, 1'b0));
        // Zero width: never contains, and the slab has no room in x.
        send_request(make_req(5, 5, 50, 50, 0, 0, 0, 20, 1'b0));
        // Zero height, but a horizontal segment runs along it.
        send_request(make_req(0, 0, 50, 0, 10, 0, 20, 0, 1'b1));
        wait_drained();
    endtask

    // One axis with no movement turns into a closed bounds check.
    task automatic test_zero_delta();
        send_request(make_req(30, -100, 30, 100, 0, 0, 60, 40, 1'b0));   // vertical through
        send_request(make_req(70, -100, 70, 100, 0, 0, 60, 40, 1'b0));   // vertical beside
        send_request(make_req(-100, 20, 100, 20, 0, 0, 60, 40, 1'b0));   // horizontal through
        send_request(make_req(-100, -5, 100, -5, 0, 0, 60, 40, 1'b0));   // horizontal above
        send_request(make_req(30, -100, 30, -10, 0, 0, 60, 40, 1'b1));   // stops short
        wait_drained();
    endtask

    // A segment of zero length only crosses on the closed rectangle's edge.
    task automatic test_degenerate();
        send_request(make_req(60, 10, 60, 10, 0, 0, 60, 40, 1'b0));      // on right edge
        send_request(make_req(10, 40, 10, 40, 0, 0, 60, 40, 1'b0));      // on bottom edge
        send_request(make_req(100, 100, 100, 100, 0, 0, 60, 40, 1'b0));  // away from it
        send_request(make_req(10, 10, 10, 10, 0, 0, 60, 40, 1'b1));      // inside, skipped
        wait_drained();
    endtask

    // Field extremes: widest rectangles and segments, all-zero fields.
    task automatic test_extremes();
        send_request(make_req(-32768, -32768, 32767, 32767,
                              32767, 32767, 65535, 65535, 1'b0));
        send_request(make_req(32767, -32768, -32768, 32767,
                              -32768, -32768, 65535, 65535, 1'b0));
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_request(make_req(32767, 32767, 32767, 32767,
                              -32768, -32768, 65535, 65535, 1'b1));
        wait_drained();
    endtask

    // The blocked flag holds across a list and clears after its last item.
    task automatic test_lists();
        send_request(make_req(-100, 20, 100, 20, 0, 50, 10, 10, 1'b0));    // miss
        send_request(make_req(-100, 20, 100, 20, 0, 0, 60, 40, 1'b0));     // cross
        send_request(make_req(-100, 20, 100, 20, 200, 200, 5, 5, 1'b1));   // miss, still blocked
        send_request(make_req(-100, 20, 100, 20, 0, 50, 10, 10, 1'b1));    // fresh list
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random lists. Most lists keep one segment and vary the rectangles near
    // it, as a real obstacle scan does. Some use axis-aligned segments, some
    // the full coordinate range, and a few are pure noise with random last
    // flags. Stretches of the run go without any idling.
    // ------------------------------------------------------------------------
    task automatic test_random_lists(input int n_requests);
        int  sent, list_len, mode, sx, sy, ex, ey, left, top, w, h;
        bit  last;
        t_in req;
        sent = 0;
        while (sent < n_requests) begin
            no_idle  = (sent % 300) < 60;
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            mode     = $urandom_range(0, 99);
            list_len = $urandom_range(1, 8);
            sx = near_coord();
            sy = near_coord();
            ex = near_coord();
            ey = near_coord();
            if (mode >= 60 && mode < 75) begin
                case ($urandom_range(0, 2))
                    0: begin
                        ex = sx;
                    end
                    1: begin
                        ey = sy;
                    end
                    default: begin
                        ex = sx;
                        ey = sy;
                    end
                endcase
            end else if (mode >= 75) begin
                sx = int'($signed(COORD_WIDTH'($urandom())));
                sy = int'($signed(COORD_WIDTH'($urandom())));
                ex = int'($signed(COORD_WIDTH'($urandom())));
                ey = int'($signed(COORD_WIDTH'($urandom())));
            end
            for (int i = 0; i < list_len; i++) begin
                last = (i == list_len - 1);
                if (mode < 75) begin
                    left = near_coord();
                    top  = near_coord();
                    w    = $urandom_range(0, 250);
                    h    = $urandom_range(0, 250);
                    // Line some edges up with the segment to hit the ties.
                    if ($urandom_range(0, 7) == 0)
                        left = sx;
                    if ($urandom_range(0, 7) == 0)
                        top = ey;
                    if ($urandom_range(0, 9) == 0)
                        w = ex - left;
                    req = make_req(sx, sy, ex, ey, left, top, w, h, last);
                end else begin
                    req = make_req(sx, sy, ex, ey, $urandom(), $urandom(),
                                   $urandom(), $urandom(), last);
                    if (mode >= 90) begin
                        // Noise: every field random, list boundaries included.
                        req = make_req($urandom(), $urandom(), $urandom(),
                                       $urandom(), $urandom(), $urandom(),
                                       $urandom(), $urandom(), $urandom_range(0, 1));
                    end
                end
                send_request(req);
                sent++;
            end
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence. Reset is held at the start and never again. After the
    // last request the bench waits for every result, then keeps checking that
    // no stray result appears before it ends the run.
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_containment();
        test_zero_delta();
        test_degenerate();
        test_extremes();
        test_lists();
        test_random_lists(1478);
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: several times the slowest legal run, with the longest gaps
    // and stalls on every request.
    initial begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
